/* design/s64dec_pkg.sv */
// Shared types, constants and helpers for the signed 64-bit to decimal text block.
// No dependencies; every other design file imports this package.
package s64dec_pkg;

    // Field widths
    localparam int NUM_W   = 64;
    localparam int CAP_W   = 8;
    localparam int LEN_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int DIGITS  = 20;
    localparam int BCD_W   = DIGITS * 4;

    // Conversion: shift-add-3, CONV_BITS input bits per cycle
    localparam int CONV_BITS  = 8;
    localparam int CONV_STEPS = NUM_W / CONV_BITS;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    // Defaults
    localparam int              FIFO_DEPTH_DEF = 2;
    localparam logic [CAP_W-1:0] CAP_RESET     = 8'd32;
    localparam logic [CAP_W-1:0] MIN_NEG_ROOM  = 8'd2;

    // Characters and status codes
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic              STATUS_OK   = 1'b0;
    localparam logic              STATUS_FULL = 1'b1;

    // One queued item: sign and magnitude
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] mag;
    } t_item;

    // Converter sequencer
    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } t_cv_state;

    // One shift-add-3 step: correct every digit, then shift in the next bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic             b);
        logic [BCD_W-1:0] fix;
        fix = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (fix[d*4 +: 4] >= 4'd5) begin
                fix[d*4 +: 4] = fix[d*4 +: 4] + 4'd3;
            end
        end
        return {fix[BCD_W-2:0], b};
    endfunction

endpackage

/* design/s64dec_front.sv */
// Front stage: takes input beats, splits sign from magnitude, registers them.
// Depends on s64dec_pkg.
module s64dec_front import s64dec_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [NUM_W-1:0] i_number,
    output logic                    o_push_valid,
    input  logic                    i_push_ready,
    output t_item                   o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  take;

    // Holding register frees up as soon as the queue takes it
    assign o_in_ready   = !r_valid || i_push_ready;
    assign take         = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_item       = r_item;

    // Sign and magnitude; the most negative value wraps to 2^63 unsigned
    always_comb begin
        n_item.neg = i_number[NUM_W-1];
        n_item.mag = n_item.neg ? (NUM_W'(0) - $unsigned(i_number)) : $unsigned(i_number);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

endmodule

/* design/s64dec_fifo.sv */
// Short queue between front and back stages.
// Depends on s64dec_pkg (item type).
module s64dec_fifo import s64dec_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

/* design/s64dec_back.sv */
// Back stage: binary to BCD converter, capacity check, character emitter, output register.
// Depends on s64dec_pkg.
module s64dec_back import s64dec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_item             i_q_item,
    input  logic [CAP_W-1:0]  i_capacity,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_character,
    output logic              o_is_last,
    output logic              o_status,
    output logic [LEN_W-1:0]  o_text_length
);

    // Converter
    t_cv_state         r_cv_state;
    t_cv_state         n_cv_state;
    logic [STEP_W-1:0] r_cv_step;
    logic [NUM_W-1:0]  r_cv_bin;
    logic [BCD_W-1:0]  r_cv_bcd;
    logic              r_cv_neg;
    logic [NUM_W-1:0]  n_cv_bin;
    logic [BCD_W-1:0]  n_cv_bcd;
    logic              cv_take;

    // Hand-over figures
    logic [LEN_W-1:0]  nd;
    logic [LEN_W-1:0]  shift;
    logic              fail;

    // Emitter
    logic              r_em_busy;
    logic              r_em_fail;
    logic              r_em_sign;
    logic [BCD_W-1:0]  r_em_digits;
    logic [LEN_W-1:0]  r_em_left;
    logic [LEN_W-1:0]  r_em_total;
    logic              em_fire;
    logic              em_end;

    // Beat under construction
    logic [CHAR_W-1:0] beat_char;
    logic              beat_last;
    logic              beat_status;
    logic [LEN_W-1:0]  beat_len;

    // Output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;
    logic              r_out_status;
    logic [LEN_W-1:0]  r_out_len;
    logic              out_load;

    // Converter sequencer
    always_comb begin
        n_cv_state = r_cv_state;
        o_q_ready  = 1'b0;
        cv_take    = 1'b0;
        case (r_cv_state)
            CV_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_cv_state = CV_RUN;
                end
            end
            CV_RUN: begin
                if (r_cv_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_cv_state = CV_DONE;
                end
            end
            CV_DONE: begin
                if (!r_em_busy) begin
                    cv_take    = 1'b1;
                    n_cv_state = CV_IDLE;
                end
            end
            default: n_cv_state = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv_state <= CV_IDLE;
        end else begin
            r_cv_state <= n_cv_state;
        end
    end

    // CONV_BITS shift-add-3 steps per cycle, MSB first
    always_comb begin
        n_cv_bcd = r_cv_bcd;
        n_cv_bin = r_cv_bin;
        for (int s = 0; s < CONV_BITS; s++) begin
            n_cv_bcd = dd_step(n_cv_bcd, n_cv_bin[NUM_W-1]);
            n_cv_bin = {n_cv_bin[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cv_state == CV_IDLE) begin
            r_cv_bin  <= i_q_item.mag;
            r_cv_bcd  <= '0;
            r_cv_neg  <= i_q_item.neg;
            r_cv_step <= '0;
        end else if (r_cv_state == CV_RUN) begin
            r_cv_bin  <= n_cv_bin;
            r_cv_bcd  <= n_cv_bcd;
            r_cv_step <= r_cv_step + 1'b1;
        end
    end

    // Digit count: highest non-zero digit, at least one
    always_comb begin
        nd = LEN_W'(1);
        for (int d = 1; d < DIGITS; d++) begin
            if (r_cv_bcd[d*4 +: 4] != 4'd0) begin
                nd = LEN_W'(d + 1);
            end
        end
        shift = LEN_W'(DIGITS) - nd;
    end

    // Room check; a sign takes one byte and needs two in all
    always_comb begin
        if (r_cv_neg) begin
            fail = (i_capacity < MIN_NEG_ROOM)
                || ((i_capacity - 8'd1) < {{(CAP_W-LEN_W){1'b0}}, nd});
        end else begin
            fail = i_capacity < {{(CAP_W-LEN_W){1'b0}}, nd};
        end
    end

    // Emitter beat
    assign out_load = !r_out_valid || i_out_ready;
    assign em_fire  = r_em_busy && out_load;
    assign em_end   = r_em_fail || (!r_em_sign && (r_em_left == LEN_W'(1)));

    always_comb begin
        if (r_em_fail) begin
            beat_char   = CHAR_NONE;
            beat_last   = 1'b1;
            beat_status = STATUS_FULL;
            beat_len    = '0;
        end else if (r_em_sign) begin
            beat_char   = CHAR_MINUS;
            beat_last   = 1'b0;
            beat_status = STATUS_OK;
            beat_len    = r_em_total;
        end else begin
            beat_char   = CHAR_ZERO + {4'b0000, r_em_digits[BCD_W-1 -: 4]};
            beat_last   = (r_em_left == LEN_W'(1));
            beat_status = STATUS_OK;
            beat_len    = r_em_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_busy <= 1'b0;
        end else if (cv_take) begin
            r_em_busy <= 1'b1;
        end else if (em_fire && em_end) begin
            r_em_busy <= 1'b0;
        end
    end

    // Digits are aligned so the leading one sits at the top nibble
    always_ff @(posedge i_clk) begin
        if (cv_take) begin
            r_em_fail   <= fail;
            r_em_sign   <= r_cv_neg;
            r_em_digits <= r_cv_bcd << {shift, 2'b00};
            r_em_left   <= nd;
            r_em_total  <= nd + LEN_W'(r_cv_neg);
        end else if (em_fire) begin
            if (r_em_sign) begin
                r_em_sign <= 1'b0;
            end else begin
                r_em_digits <= {r_em_digits[BCD_W-5:0], 4'b0000};
                r_em_left   <= r_em_left - 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_em_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_fire) begin
            r_out_char   <= beat_char;
            r_out_last   <= beat_last;
            r_out_status <= beat_status;
            r_out_len    <= beat_len;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_character   = r_out_char;
    assign o_is_last     = r_out_last;
    assign o_status      = r_out_status;
    assign o_text_length = r_out_len;

endmodule

/* design/signed_int64_to_decimal_ascii.sv */
// Signed 64-bit to decimal text converter: top level, capacity register, checks.
// Depends on s64dec_pkg, s64dec_front, s64dec_fifo and s64dec_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_number) takes one signed value per beat.
//   Output channel (o_out_valid/i_out_ready) gives one character per beat: '-' first
//   for a negative value, then the digits most significant first; o_text_length
//   carries the full length on every beat and o_is_last marks the final one.
//   If the text does not fit i_cfg_data bytes of room, one beat with o_status high,
//   character 0 and length 0 is given instead.
//   Config channel (i_cfg_valid/o_cfg_ready) writes the capacity; it is always ready
//   and is to be written only while no conversion is in flight.
//   Converter and emitter: the converter loads a value, runs 8 steps of 8-bit
//   shift-add-3 and hands over; the emitter gives one character per cycle while the
//   output register can load, and the two overlap.
//   The queue holds two values by default, so the input stays ready while results drain until it fills.
//   Reset (synchronous, active low) empties every stage and sets capacity to 32.
//   A stalled receiver holds the output register; the emitter, converter, queue
//   and front stage then fill in turn before o_in_ready drops.
module signed_int64_to_decimal_ascii import s64dec_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [NUM_W-1:0] i_number,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_is_last,
    output logic                    o_status,
    output logic [LEN_W-1:0]        o_text_length,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CAP_W-1:0]        i_cfg_data
);

    logic [CAP_W-1:0] r_capacity;
    logic             push_valid;
    logic             push_ready;
    t_item            push_item;
    logic             pop_valid;
    logic             pop_ready;
    t_item            pop_item;

    // Capacity register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    s64dec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_number     (i_number),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    s64dec_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    s64dec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (pop_valid),
        .o_q_ready     (pop_ready),
        .i_q_item      (pop_item),
        .i_capacity    (r_capacity),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_character   (o_character),
        .o_is_last     (o_is_last),
        .o_status      (o_status),
        .o_text_length (o_text_length)
    );

    // A failure beat stands alone and carries no text
    a_fail_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_FULL))
        |-> (o_is_last && (o_text_length == '0) && (o_character == CHAR_NONE)))
        else $error("failure beat carries text");

    // Text beats carry a length of one to twenty and a sign or digit character
    a_text_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_OK))
        |-> ((o_text_length != '0) && (o_text_length <= LEN_W'(DIGITS))
             && ((o_character == CHAR_MINUS)
                 || ((o_character >= CHAR_ZERO) && (o_character <= CHAR_ZERO + 8'd9)))))
        else $error("malformed text beat");

    // A minus sign is never the last beat
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_OK) && (o_character == CHAR_MINUS))
        |-> !o_is_last)
        else $error("sign given as last beat");

    // Capacity only moves on a config beat
    a_cap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg_valid |=> $stable(r_capacity))
        else $error("capacity changed without a config beat");

endmodule

/* dv/signed_int64_to_decimal_ascii_tb.sv */
// Testbench for signed_int64_to_decimal_ascii: drives signed values, predicts the decimal text
// beat by beat and checks every output beat. Depends on s64dec_pkg and the design top level.
module signed_int64_to_decimal_ascii_tb import s64dec_pkg::*; ;

    // One expected output beat
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              status;
        logic [LEN_W-1:0]  len;
    } t_char_beat;

    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic signed [NUM_W-1:0] i_number    = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [CHAR_W-1:0]       o_character;
    logic                    o_is_last;
    logic                    o_status;
    logic [LEN_W-1:0]        o_text_length;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CAP_W-1:0]        i_cfg_data  = '0;

    // Stimulus and prediction state
    logic signed [NUM_W-1:0] pending_numbers[$];
    t_char_beat              text_beats[$];
    logic [CAP_W-1:0]        capacity_now = CAP_RESET;
    logic                    sender_gaps_on = 1'b1;
    int                      burst_left = 1;
    int                      gap_left = 0;
    int                      fail_count = 0;
    int                      rx_cycle = 0;
    int                      rx_beats = 0;
    int                      hold_left = 0;

    signed_int64_to_decimal_ascii i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_number     (i_number),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_character  (o_character),
        .o_is_last    (o_is_last),
        .o_status     (o_status),
        .o_text_length(o_text_length),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Expected text of one value: sign, then digits most significant first, or one
    // failure beat when the text does not fit the room available
    function automatic void predict_text(input logic signed [NUM_W-1:0] value,
                                         input logic [CAP_W-1:0]        room_cfg);
        logic [NUM_W-1:0]  mag;
        logic [CHAR_W-1:0] digit_chars[DIGITS];
        logic              neg;
        logic              fits;
        int                nd;
        int                room;
        int                total;
        t_char_beat        b;
        neg = value[NUM_W-1];
        mag = value;
        if (neg) begin
            mag = -mag;
        end
        nd = 0;
        do begin
            digit_chars[nd] = CHAR_ZERO + CHAR_W'(mag % 10);
            mag = mag / 10;
            nd++;
        end while (mag != 0 && nd < DIGITS);
        // a minus needs its own byte plus at least one digit
        if (neg && room_cfg < MIN_NEG_ROOM) begin
            fits = 1'b0;
        end else begin
            room = int'(room_cfg) - int'(neg);
            fits = (room >= nd);
        end
        if (!fits) begin
            b = '{ch: CHAR_NONE, last: 1'b1, status: STATUS_FULL, len: '0};
            text_beats.push_back(b);
            return;
        end
        total = nd + int'(neg);
        if (neg) begin
            b = '{ch: CHAR_MINUS, last: 1'b0, status: STATUS_OK, len: LEN_W'(total)};
            text_beats.push_back(b);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            b = '{ch: digit_chars[i], last: (i == 0), status: STATUS_OK,
                  len: LEN_W'(total)};
            text_beats.push_back(b);
        end
    endfunction

    // Random value: raw patterns, extremes, powers of ten and their neighbours,
    // and values of a chosen digit count so that lengths spread evenly
    function automatic logic signed [NUM_W-1:0] rand_number();
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] lo;
        logic [NUM_W-1:0] span;
        int               k;
        k = $urandom_range(1, 19);
        lo = 64'd1;
        for (int i = 1; i < k; i++) begin
            lo = lo * 10;
        end
        case ($urandom_range(0, 9))
            0, 1: begin
                return {$urandom, $urandom};
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 64'sh8000_0000_0000_0000;
                    1: return 64'sh7FFF_FFFF_FFFF_FFFF;
                    2: return 64'sd0;
                    default: return -64'sd1;
                endcase
            end
            3: begin
                mag = lo - 1 + $urandom_range(0, 2);
            end
            default: begin
                span = (k == 19) ? (64'h8000_0000_0000_0000 - lo) : (lo * 9);
                mag = lo + ({$urandom, $urandom} % span);
            end
        endcase
        if ($urandom_range(0, 1) == 1) begin
            return -mag;
        end
        return mag;
    endfunction

    // Sender: offers queued values, in bursts while gaps are on; predicts each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_number   <= '0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_text(i_number, capacity_now);
            end
            if (i_in_valid && !o_in_ready) begin
                // beat still on offer: hold valid and payload
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_numbers.size() != 0) begin
                i_in_valid <= 1'b1;
                i_number   <= pending_numbers.pop_front();
                if (sender_gaps_on) begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                               : $urandom_range(0, 4);
                    end
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern steps through four modes as the cycle counter advances; a long hold-off now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_cycle  = 0;
            rx_beats  = 0;
            hold_left = 0;
        end else begin
            rx_cycle++;
            if (o_out_valid && i_out_ready) begin
                rx_beats++;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready && rx_beats % 500 == 250) begin
                hold_left = 150;
                i_out_ready <= 1'b0;
            end else begin
                case ((rx_cycle >> 7) % 4)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 1) == 1);
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ((rx_cycle & 2) != 0);
                endcase
            end
        end
    end

    // Monitor: each output beat against the oldest expected one
    always @(posedge i_clk) begin : check_beats
        t_char_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (text_beats.size() == 0) begin
                $error("unexpected beat: character %h is_last %b status %b length %0d",
                       o_character, o_is_last, o_status, o_text_length);
                fail_count++;
            end else begin
                want = text_beats.pop_front();
                if (o_character !== want.ch) begin
                    $error("character: expected %h, got %h", want.ch, o_character);
                    fail_count++;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last: expected %b, got %b", want.last, o_is_last);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_status);
                    fail_count++;
                end
                if (o_text_length !== want.len) begin
                    $error("text_length: expected %0d, got %0d", want.len, o_text_length);
                    fail_count++;
                end
            end
        end
    end

    // Block until nothing is queued, offered or outstanding; sampled mid-cycle so the
    // sender's updates at the rising edge have settled
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_numbers.size() != 0 || i_in_valid || text_beats.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    // Capacity write; called only while the block is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        capacity_now = cap;
        i_cfg_valid <= 1'b0;
    endtask

    // Random values; the sender pauses half way until the block has drained
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                wait_idle();
            end
            pending_numbers.push_back(rand_number());
        end
        wait_idle();
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] random_caps[9];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed values at the reset capacity
        pending_numbers = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, 64'sd99,
                            64'sd100, -64'sd100, 64'sd999999999999999999,
                            64'sd1000000000000000000, -64'sd1000000000000000000,
                            64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0001,
                            64'sh8000_0000_0000_0000, 64'sh5555_5555_5555_5555,
                            64'shAAAA_AAAA_AAAA_AAAA};
        wait_idle();

        // No room at all: every value fails
        write_capacity(8'd0);
        pending_numbers = '{64'sd0, 64'sd7};
        wait_idle();
        // One byte: a digit fits, a minus never does
        write_capacity(8'd1);
        pending_numbers = '{64'sd5, -64'sd5, 64'sd10};
        wait_idle();
        // Two bytes: the smallest room for a negative value
        write_capacity(8'd2);
        pending_numbers = '{-64'sd5, -64'sd10, 64'sd99};
        wait_idle();
        // 19 digits fit, but not with a sign
        write_capacity(8'd19);
        pending_numbers = '{64'sh7FFF_FFFF_FFFF_FFFF, 64'sh8000_0000_0000_0000,
                            64'sh8000_0000_0000_0001};
        wait_idle();
        write_capacity(8'd20);
        pending_numbers = '{64'sh8000_0000_0000_0000};
        wait_idle();

        // Random phases over several capacities, gaps on and off in turn
        random_caps = '{8'd255, 8'd32, 8'd19, 8'd1, 8'd12, 8'd0, 8'd2, 8'd20, 8'd0};
        random_caps[4] = $urandom_range(3, 18);
        random_caps[8] = $urandom_range(0, 255);
        for (int p = 0; p < 9; p++) begin
            write_capacity(random_caps[p]);
            sender_gaps_on = (p % 2 == 0);
            run_random(39);
        end

        if (fail_count == 0) begin
            $display("signed_int64_to_decimal_ascii test passed");
        end else begin
            $display("signed_int64_to_decimal_ascii test failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("signed_int64_to_decimal_ascii test failed");
        $finish;
    end

endmodule

/* filelist.f */
design/s64dec_pkg.sv
design/s64dec_front.sv
design/s64dec_fifo.sv
design/s64dec_back.sv
design/signed_int64_to_decimal_ascii.sv
dv/signed_int64_to_decimal_ascii_tb.sv
